>>> src/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg - shared constants for the biquad cascade
// Default sizes, register indexes, function codes, reset values and coefficient slots.
// ----------------------------------------------------------------------------
package bcs_pkg;

   localparam int DEF_MAX_SECTIONS  = 8;
   localparam int DEF_DATA_WIDTH    = 32;
   localparam int COEFS_PER_SECTION = 6;
   localparam int HIST_PER_SECTION  = 4;
   localparam int COEF_W            = 32;
   localparam int CSR_IDX_W         = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SECTION_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MAX    = 2'd2;

   localparam logic        FUNC_LOAD   = 1'b0;
   localparam logic        FUNC_FILTER = 1'b1;

   localparam logic [2:0]  SEL_B0 = 3'd0;
   localparam logic [2:0]  SEL_B1 = 3'd1;
   localparam logic [2:0]  SEL_B2 = 3'd2;
   localparam logic [2:0]  SEL_A0 = 3'd3;
   localparam logic [2:0]  SEL_A1 = 3'd4;
   localparam logic [2:0]  SEL_A2 = 3'd5;

   localparam logic [3:0]         RST_SECTION_COUNT = 4'd1;
   localparam logic signed [31:0] RST_OUTPUT_MIN    = -32'sd491520;
   localparam logic signed [31:0] RST_OUTPUT_MAX    = 32'sd491520;

endpackage

>>> src/bcs_ram.sv
// ----------------------------------------------------------------------------
// bcs_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bcs_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/biquad_cascade_saturating.sv
// ----------------------------------------------------------------------------
// biquad_cascade_saturating - cascade of direct-form-I biquads, Q16.16
// Shared multiplier, accumulator and restoring divider under one sequencer.
//
//   channel | direction | handshake           | word
//   req     | in        | req_valid/req_ready | load coefficient or sample
//   rsp     | out       | rsp_valid/rsp_ready | control_out, limited
//   csr     | in        | csr_valid/csr_ready | register index, data
//
// A load word is written straight into the coefficient RAM. A sample word
// runs per section a load of coefficients and history, 5 terms on the 32x16
// multiplier in 16-bit chunks of the operand, a restoring division, a quotient
// step and 4 history writes, then the result is handed to the output register.
// Reset clears history valid bits at once; no clearing pass.
// req_ready is low while a sample is in work; a result waiting in the
// output register stalls only the next sample's hand-off.
// ----------------------------------------------------------------------------
module biquad_cascade_saturating #(
   parameter int MAX_SECTIONS = bcs_pkg::DEF_MAX_SECTIONS,
   parameter int DATA_WIDTH   = bcs_pkg::DEF_DATA_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [2:0]                    req_section_index,
   input  logic [2:0]                    req_coef_select,
   input  logic signed [31:0]            req_coef_value,
   input  logic signed [31:0]            req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_control_out,
   output logic                          rsp_limited,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);

   import bcs_pkg::*;

   localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int C_DEPTH   = MAX_SECTIONS * COEFS_PER_SECTION;
   localparam int H_DEPTH   = MAX_SECTIONS * HIST_PER_SECTION;
   localparam int CA_W      = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
   localparam int HA_W      = (H_DEPTH > 1) ? $clog2(H_DEPTH) : 1;
   localparam int MUL_STEPS = (DATA_WIDTH + 15) / 16;
   localparam int MS_W      = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
   localparam int XP_W      = MUL_STEPS * 16;
   localparam int PW        = COEF_W + XP_W;
   localparam int EW        = (PW > 64) ? PW : 64;
   localparam int CW        = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

   localparam logic [63:0] FMT_MAX64 = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
   localparam logic signed [CW-1:0] FMT_MAX_C = CW'(FMT_MAX64);
   localparam logic signed [CW-1:0] FMT_MIN_C = ~FMT_MAX_C;
   localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LOAD = 8'b0000_0010,
      ST_MUL  = 8'b0000_0100,
      ST_ACC  = 8'b0000_1000,
      ST_DIV  = 8'b0001_0000,
      ST_QUOT = 8'b0010_0000,
      ST_WB   = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type                    state_ff;
   logic [3:0]                   cfg_count_ff;
   logic signed [31:0]           cfg_min_ff;
   logic signed [31:0]           cfg_max_ff;
   logic [SEC_W-1:0]             sec_ff;
   logic [2:0]                   ld_ff;
   logic [2:0]                   term_ff;
   logic [MS_W-1:0]              mstep_ff;
   logic [1:0]                   wb_ff;
   logic [5:0]                   dcnt_ff;
   logic signed [COEF_W-1:0]     c_ff [COEFS_PER_SECTION];
   logic signed [DATA_WIDTH-1:0] h_ff [HIST_PER_SECTION];
   logic signed [DATA_WIDTH-1:0] x_ff;
   logic [PW-1:0]                p_ff;
   logic signed [63:0]           acc_ff;
   logic [32:0]                  rem_ff;
   logic [63:0]                  quo_ff;
   logic [31:0]                  den_ff;
   logic                         neg_ff;
   logic                         den_zero_ff;
   logic signed [CW-1:0]         y_ff;
   logic                         lim_ff;
   logic                         rsp_valid_ff;
   logic signed [31:0]           rsp_out_ff;
   logic                         rsp_lim_ff;
   logic                         hist_vld_ff [H_DEPTH];
   logic                         hv_rd_ff;

   logic                         req_fire;
   logic                         coef_we;
   logic [CA_W-1:0]              coef_wa;
   logic [CA_W-1:0]              coef_ra;
   logic [COEF_W-1:0]            coef_rd;
   logic                         hist_we;
   logic [HA_W-1:0]              hist_wa;
   logic [HA_W-1:0]              hist_ra;
   logic [DATA_WIDTH-1:0]        hist_wd;
   logic [DATA_WIDTH-1:0]        hist_rd;
   logic signed [DATA_WIDTH-1:0] hist_val;
   logic [SEC_W-1:0]             last_sec;
   logic signed [63:0]           samp64;
   logic signed [DATA_WIDTH-1:0] samp_sat;
   logic signed [COEF_W-1:0]     m_coef;
   logic signed [DATA_WIDTH-1:0] m_val;
   logic [31:0]                  m_ca;
   logic [DATA_WIDTH-1:0]        m_xv;
   logic [XP_W-1:0]              m_xpad;
   logic [15:0]                  m_chunk;
   logic [47:0]                  m_prod;
   logic [PW-1:0]                p_in;
   logic                         m_neg;
   logic [EW-1:0]                p_ext;
   logic [63:0]                  p_mag;
   logic signed [63:0]           term;
   logic signed [64:0]           sum;
   logic signed [63:0]           acc_in;
   logic [33:0]                  d_try;
   logic                         d_bit;
   logic signed [CW-1:0]         yq;
   logic signed [CW-1:0]         y_in;
   logic                         lim_in;
   logic signed [CW-1:0]         lo_c;
   logic signed [CW-1:0]         hi_c;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      if (cfg_count_ff == 4'd0) begin
         last_sec = '0;
      end else if (32'(cfg_count_ff) > MAX_SECTIONS) begin
         last_sec = SEC_W'(MAX_SECTIONS - 1);
      end else begin
         last_sec = SEC_W'(cfg_count_ff - 4'd1);
      end
   end

   always_comb begin
      samp64 = 64'(req_sample_in);
      if (samp64 > $signed(FMT_MAX64)) begin
         samp_sat = DATA_WIDTH'(FMT_MAX_C);
      end else if (samp64 < $signed(~FMT_MAX64)) begin
         samp_sat = DATA_WIDTH'(FMT_MIN_C);
      end else begin
         samp_sat = DATA_WIDTH'(samp64);
      end
   end

   assign coef_we = req_fire && (req_func == FUNC_LOAD)
                    && (32'(req_section_index) < MAX_SECTIONS)
                    && (32'(req_coef_select) < COEFS_PER_SECTION);
   assign coef_wa = CA_W'(32'(req_section_index) * COEFS_PER_SECTION
                          + 32'(req_coef_select));
   assign coef_ra = CA_W'(32'(sec_ff) * COEFS_PER_SECTION + 32'(ld_ff));
   assign hist_ra = HA_W'(32'(sec_ff) * HIST_PER_SECTION + 32'(ld_ff[1:0]));
   assign hist_wa = HA_W'(32'(sec_ff) * HIST_PER_SECTION + 32'(wb_ff));
   assign hist_we = (state_ff == ST_WB);
   assign hist_val = hv_rd_ff ? $signed(hist_rd) : '0;

   always_comb begin
      case (wb_ff)
         2'd0:    hist_wd = x_ff;
         2'd1:    hist_wd = h_ff[0];
         2'd2:    hist_wd = DATA_WIDTH'(y_ff);
         default: hist_wd = h_ff[2];
      endcase
   end

   bcs_ram #(.WIDTH(COEF_W), .DEPTH(C_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_wa),
      .wr_data (req_coef_value),
      .rd_addr (coef_ra),
      .rd_data (coef_rd)
   );

   bcs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(H_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wa),
      .wr_data (hist_wd),
      .rd_addr (hist_ra),
      .rd_data (hist_rd)
   );

   always_comb begin
      case (term_ff)
         3'd0: begin
            m_coef = c_ff[SEL_B0];
            m_val  = x_ff;
         end
         3'd1: begin
            m_coef = c_ff[SEL_B1];
            m_val  = h_ff[0];
         end
         3'd2: begin
            m_coef = c_ff[SEL_B2];
            m_val  = h_ff[1];
         end
         3'd3: begin
            m_coef = c_ff[SEL_A1];
            m_val  = h_ff[2];
         end
         default: begin
            m_coef = c_ff[SEL_A2];
            m_val  = h_ff[3];
         end
      endcase
      m_ca    = m_coef[COEF_W-1] ? 32'(-m_coef) : 32'(m_coef);
      m_xv    = m_val[DATA_WIDTH-1] ? DATA_WIDTH'(-m_val) : DATA_WIDTH'(m_val);
      m_xpad  = XP_W'(m_xv);
      m_chunk = m_xpad[(MUL_STEPS - 1 - int'(mstep_ff)) * 16 +: 16];
      m_prod  = 48'(m_ca) * 48'(m_chunk);
      p_in    = (p_ff << 16) + PW'(m_prod);
      m_neg   = m_coef[COEF_W-1] ^ m_val[DATA_WIDTH-1] ^ (term_ff >= 3'd3);
      p_ext   = EW'(p_ff);
      p_mag   = (p_ext > EW'(I64_MAX)) ? I64_MAX : p_ext[63:0];
      term    = m_neg ? -$signed(p_mag) : $signed(p_mag);
      sum     = 65'(acc_ff) + 65'(term);
      if (sum > 65'(I64_MAX)) begin
         acc_in = I64_MAX;
      end else if (sum < 65'(I64_MIN)) begin
         acc_in = I64_MIN;
      end else begin
         acc_in = 64'(sum);
      end
   end

   assign d_try = {rem_ff, quo_ff[63]};
   assign d_bit = (d_try >= 34'(den_ff));

   always_comb begin
      lo_c = CW'(cfg_min_ff);
      hi_c = CW'(cfg_max_ff);
      if (den_zero_ff) begin
         if (acc_ff > 0) begin
            yq = FMT_MAX_C;
         end else if (acc_ff < 0) begin
            yq = FMT_MIN_C;
         end else begin
            yq = '0;
         end
      end else if (neg_ff) begin
         yq = (quo_ff > FMT_MAX64 + 64'd1) ? FMT_MIN_C : -CW'(quo_ff);
      end else begin
         yq = (quo_ff > FMT_MAX64) ? FMT_MAX_C : CW'(quo_ff);
      end
      y_in   = yq;
      lim_in = 1'b0;
      if (sec_ff == last_sec) begin
         if (yq < lo_c) begin
            y_in   = lo_c;
            lim_in = 1'b1;
         end else if (yq > hi_c) begin
            y_in   = hi_c;
            lim_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_count_ff <= RST_SECTION_COUNT;
         cfg_min_ff   <= RST_OUTPUT_MIN;
         cfg_max_ff   <= RST_OUTPUT_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SECTION_COUNT: cfg_count_ff <= csr_data[3:0];
            CSR_OUTPUT_MIN:    cfg_min_ff   <= csr_data;
            CSR_OUTPUT_MAX:    cfg_max_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < H_DEPTH; i++) begin
            hist_vld_ff[i] <= 1'b0;
         end
      end else if (hist_we) begin
         hist_vld_ff[hist_wa] <= 1'b1;
      end
      hv_rd_ff <= hist_vld_ff[hist_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sec_ff       <= '0;
         ld_ff        <= '0;
         term_ff      <= '0;
         mstep_ff     <= '0;
         wb_ff        <= '0;
         dcnt_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_func == FUNC_FILTER)) begin
                  x_ff     <= samp_sat;
                  sec_ff   <= '0;
                  ld_ff    <= '0;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               if (ld_ff != 3'd0) begin
                  c_ff[ld_ff - 3'd1] <= coef_rd;
                  if (ld_ff <= 3'd4) begin
                     h_ff[2'(ld_ff - 3'd1)] <= hist_val;
                  end
               end
               if (ld_ff == 3'(COEFS_PER_SECTION)) begin
                  term_ff  <= '0;
                  mstep_ff <= '0;
                  p_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= ST_MUL;
               end else begin
                  ld_ff <= ld_ff + 3'd1;
               end
            end
            ST_MUL: begin
               p_ff <= p_in;
               if (mstep_ff == MS_W'(MUL_STEPS - 1)) begin
                  state_ff <= ST_ACC;
               end else begin
                  mstep_ff <= mstep_ff + 1'b1;
               end
            end
            ST_ACC: begin
               acc_ff   <= acc_in;
               p_ff     <= '0;
               mstep_ff <= '0;
               if (term_ff == 3'd4) begin
                  rem_ff      <= '0;
                  quo_ff      <= acc_in[63] ? 64'(-acc_in) : 64'(acc_in);
                  den_ff      <= c_ff[SEL_A0][31] ? 32'(-c_ff[SEL_A0])
                                                  : 32'(c_ff[SEL_A0]);
                  neg_ff      <= acc_in[63] ^ c_ff[SEL_A0][31];
                  den_zero_ff <= (c_ff[SEL_A0] == '0);
                  dcnt_ff     <= '0;
                  state_ff    <= ST_DIV;
               end else begin
                  term_ff  <= term_ff + 3'd1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DIV: begin
               rem_ff <= d_bit ? 33'(d_try - 34'(den_ff)) : 33'(d_try);
               quo_ff <= {quo_ff[62:0], d_bit};
               if (dcnt_ff == 6'd63) begin
                  state_ff <= ST_QUOT;
               end else begin
                  dcnt_ff <= dcnt_ff + 6'd1;
               end
            end
            ST_QUOT: begin
               y_ff     <= y_in;
               lim_ff   <= lim_in;
               wb_ff    <= '0;
               state_ff <= ST_WB;
            end
            ST_WB: begin
               if (wb_ff == 2'd3) begin
                  x_ff <= DATA_WIDTH'(y_ff);
                  if (sec_ff == last_sec) begin
                     state_ff <= ST_OUT;
                  end else begin
                     sec_ff   <= sec_ff + 1'b1;
                     ld_ff    <= '0;
                     state_ff <= ST_LOAD;
                  end
               end else begin
                  wb_ff <= wb_ff + 2'd1;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_out_ff   <= y_ff[31:0];
                  rsp_lim_ff   <= lim_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_control_out = rsp_out_ff;
   assign rsp_limited     = rsp_lim_ff;

`ifndef SYNTHESIS
   a_out_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff && req_ready)
      else $error("result not handed to output register");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && !den_zero_ff |-> (rem_ff < 33'(den_ff)))
      else $error("divider remainder out of range");

   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (sec_ff <= last_sec))
      else $error("section counter past last section");
`endif

endmodule
